/* rtl/blx_pkg.sv */
// ----------------------------------------------------------------------------
// blx_pkg
// Shared types, character codes and helpers for the byte stream lexer.
// ----------------------------------------------------------------------------
package blx_pkg;

  localparam int OffsetBitsDefault = 16;
  localparam int QueueDepth        = 4;
  localparam int QueuePtrBits      = $clog2(QueueDepth);
  localparam int QueueCntBits      = $clog2(QueueDepth + 1);

  typedef enum logic [1:0] {
    KIND_NAME   = 2'd0,
    KIND_NUMBER = 2'd1,
    KIND_SYMBOL = 2'd2,
    KIND_END    = 2'd3
  } kind_t;

  localparam logic [7:0] CharNul    = 8'h00;
  localparam logic [7:0] CharTab    = 8'h09;
  localparam logic [7:0] CharLf     = 8'h0a;
  localparam logic [7:0] CharSpace  = 8'h20;
  localparam logic [7:0] CharBang   = 8'h21;
  localparam logic [7:0] CharPct    = 8'h25;
  localparam logic [7:0] CharAmp    = 8'h26;
  localparam logic [7:0] CharLParen = 8'h28;
  localparam logic [7:0] CharRParen = 8'h29;
  localparam logic [7:0] CharStar   = 8'h2a;
  localparam logic [7:0] CharPlus   = 8'h2b;
  localparam logic [7:0] CharComma  = 8'h2c;
  localparam logic [7:0] CharMinus  = 8'h2d;
  localparam logic [7:0] CharSlash  = 8'h2f;
  localparam logic [7:0] CharZero   = 8'h30;
  localparam logic [7:0] CharNine   = 8'h39;
  localparam logic [7:0] CharSemi   = 8'h3b;
  localparam logic [7:0] CharLess   = 8'h3c;
  localparam logic [7:0] CharEq     = 8'h3d;
  localparam logic [7:0] CharGreat  = 8'h3e;
  localparam logic [7:0] CharLBrace = 8'h7b;
  localparam logic [7:0] CharBar    = 8'h7c;
  localparam logic [7:0] CharRBrace = 8'h7d;

  typedef struct packed {
    kind_t       kind;
    logic [15:0] symbol_code;
    logic [15:0] start_res;
    logic [15:0] length;
    logic        last;
  } token_t;

  // up to two tokens produced by one source byte
  typedef struct packed {
    logic [1:0] count;
    token_t     tok0;
    token_t     tok1;
  } token_pair_t;

  // partner byte that completes a two-byte symbol, zero if none
  function automatic logic [7:0] partner_of(input logic [7:0] c);
    logic [7:0] p;
    p = CharNul;
    case (c) inside
      CharBang, CharPlus, CharMinus, CharStar, CharSlash,
      CharPct, CharLess, CharGreat, CharEq: p = CharEq;
      CharAmp: p = CharAmp;
      CharBar: p = CharBar;
      default: p = CharNul;
    endcase
    return p;
  endfunction

  function automatic logic is_single_symbol(input logic [7:0] c);
    logic r;
    r = 1'b0;
    case (c) inside
      CharSemi, CharLParen, CharRParen, CharLBrace, CharRBrace, CharComma: r = 1'b1;
      default: r = 1'b0;
    endcase
    return r;
  endfunction

  function automatic logic is_blank(input logic [7:0] c);
    logic r;
    r = 1'b0;
    case (c) inside
      CharSpace, CharTab, CharLf: r = 1'b1;
      default: r = 1'b0;
    endcase
    return r;
  endfunction

endpackage

/* rtl/blx_scan.sv */
// ----------------------------------------------------------------------------
// blx_scan
// Lexer state and per-byte token decode, up to two tokens per byte.
// ----------------------------------------------------------------------------
module blx_scan #(
  parameter int OFFSET_BITS = blx_pkg::OffsetBitsDefault
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               take,
  input  logic [7:0]         ch,
  output blx_pkg::token_pair_t toks
);

  logic [OFFSET_BITS-1:0] offset, offset_next;
  logic [OFFSET_BITS-1:0] word_start, word_start_next;
  logic                   in_word, in_word_next;
  logic                   word_is_number, word_is_number_next;
  logic                   symbol_pending, symbol_pending_next;
  logic [7:0]             pending_char, pending_char_next;

  logic [OFFSET_BITS-1:0] offset_inc, prev_offset, word_len;
  logic [15:0]            off16, prev16, len16;
  logic [7:0]             want;
  logic                   pair_hit, word_byte, flush, has_first, has_second;
  blx_pkg::token_t        first_tok, second_tok;

  always_comb begin
    offset_inc  = offset + OFFSET_BITS'(1);
    prev_offset = offset - OFFSET_BITS'(1);
    word_len    = offset - word_start;
    off16       = 16'(32'(offset));
    prev16      = 16'(32'(prev_offset));
    len16       = 16'(32'(word_len));
    want        = blx_pkg::partner_of(ch);
    pair_hit    = symbol_pending && (ch != blx_pkg::CharNul) &&
                  (ch == blx_pkg::partner_of(pending_char));
    word_byte   = (ch != blx_pkg::CharNul) && !blx_pkg::is_blank(ch) &&
                  !blx_pkg::is_single_symbol(ch) && (want == blx_pkg::CharNul);
    flush       = in_word && !word_byte;
  end

  // token assembly
  always_comb begin
    first_tok  = '0;
    second_tok = '0;
    toks       = '0;
    has_first  = 1'b0;
    has_second = 1'b0;
    if (pair_hit) begin
      first_tok.kind        = blx_pkg::KIND_SYMBOL;
      first_tok.symbol_code = {pending_char, ch};
      first_tok.start_res   = prev16;
      first_tok.length      = 16'd2;
      first_tok.last        = 1'b1;
      toks.count            = 2'd1;
      toks.tok0             = first_tok;
    end else begin
      if (symbol_pending) begin
        has_first             = 1'b1;
        first_tok.kind        = blx_pkg::KIND_SYMBOL;
        first_tok.symbol_code = {8'd0, pending_char};
        first_tok.start_res   = prev16;
        first_tok.length      = 16'd1;
      end else if (flush) begin
        has_first             = 1'b1;
        first_tok.kind        = word_is_number ? blx_pkg::KIND_NUMBER : blx_pkg::KIND_NAME;
        first_tok.start_res   = 16'(32'(word_start));
        first_tok.length      = len16;
      end
      if (ch == blx_pkg::CharNul) begin
        has_second           = 1'b1;
        second_tok.kind      = blx_pkg::KIND_END;
        second_tok.start_res = off16;
        second_tok.length    = 16'd1;
      end else if (blx_pkg::is_single_symbol(ch)) begin
        has_second             = 1'b1;
        second_tok.kind        = blx_pkg::KIND_SYMBOL;
        second_tok.symbol_code = {8'd0, ch};
        second_tok.start_res   = off16;
        second_tok.length      = 16'd1;
      end
      second_tok.last = 1'b1;
      if (has_first && has_second) begin
        toks.count = 2'd2;
        toks.tok0  = first_tok;
        toks.tok1  = second_tok;
      end else if (has_first) begin
        first_tok.last = 1'b1;
        toks.count     = 2'd1;
        toks.tok0      = first_tok;
      end else if (has_second) begin
        toks.count = 2'd1;
        toks.tok0  = second_tok;
      end
    end
  end

  // state update
  always_comb begin
    offset_next         = offset_inc;
    word_start_next     = word_start;
    in_word_next        = in_word;
    word_is_number_next = word_is_number;
    symbol_pending_next = 1'b0;
    pending_char_next   = pending_char;
    if (pair_hit) begin
      offset_next = offset_inc;
    end else if (ch == blx_pkg::CharNul) begin
      offset_next         = '0;
      word_start_next     = '0;
      in_word_next        = 1'b0;
      word_is_number_next = 1'b0;
      pending_char_next   = blx_pkg::CharNul;
    end else if (word_byte) begin
      if (!in_word) begin
        in_word_next        = 1'b1;
        word_start_next     = offset;
        word_is_number_next = (ch >= blx_pkg::CharZero) && (ch <= blx_pkg::CharNine);
      end
    end else begin
      in_word_next = 1'b0;
      if (want != blx_pkg::CharNul) begin
        symbol_pending_next = 1'b1;
        pending_char_next   = ch;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      offset         <= '0;
      word_start     <= '0;
      in_word        <= 1'b0;
      word_is_number <= 1'b0;
      symbol_pending <= 1'b0;
      pending_char   <= blx_pkg::CharNul;
    end else if (take) begin
      offset         <= offset_next;
      word_start     <= word_start_next;
      in_word        <= in_word_next;
      word_is_number <= word_is_number_next;
      symbol_pending <= symbol_pending_next;
      pending_char   <= pending_char_next;
    end
  end

endmodule

/* rtl/blx_queue.sv */
// ----------------------------------------------------------------------------
// blx_queue
// Token result queue, two writes and one read per cycle.
// ----------------------------------------------------------------------------
module blx_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  blx_pkg::token_pair_t toks,
  output logic                 room,
  output logic                 head_valid,
  input  logic                 pop,
  output blx_pkg::token_t      head
);

  localparam int Pb = blx_pkg::QueuePtrBits;
  localparam int Cb = blx_pkg::QueueCntBits;

  blx_pkg::token_t entries [blx_pkg::QueueDepth];
  logic [Pb-1:0]   wr_ptr, wr_ptr_next, rd_ptr, rd_ptr_next, wr_ptr_b;
  logic [Cb-1:0]   count, count_next, n_in, n_out;

  always_comb begin
    room        = count <= Cb'(blx_pkg::QueueDepth - 2);
    head_valid  = count != '0;
    head        = entries[rd_ptr];
    n_in        = push ? Cb'(toks.count) : '0;
    n_out       = (pop && head_valid) ? Cb'(1) : '0;
    count_next  = count + n_in - n_out;
    wr_ptr_b    = wr_ptr + Pb'(1);
    wr_ptr_next = wr_ptr + Pb'(n_in);
    rd_ptr_next = rd_ptr + Pb'(n_out);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr_next;
      rd_ptr <= rd_ptr_next;
      count  <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push && (toks.count != 2'd0)) begin
      entries[wr_ptr] <= toks.tok0;
    end
    if (push && (toks.count == 2'd2)) begin
      entries[wr_ptr_b] <= toks.tok1;
    end
  end

endmodule

/* rtl/byte_stream_lexer_unit.sv */
// ----------------------------------------------------------------------------
// byte_stream_lexer_unit
// Streaming lexer: one source byte in per request, name, number, symbol and
// end tokens out through a small result queue.
// ----------------------------------------------------------------------------
// output: tokens are registered in the result queue before they reach the output
// throughput: one byte per cycle; a byte is taken while the four-entry result
//   queue has two free slots, so bytes that make two tokens briefly stall input
//   when the output drains one token per cycle
// reset: clears the lexer state (offset, pending word and symbol) and the queue
module byte_stream_lexer_unit #(
  parameter int OFFSET_BITS = blx_pkg::OffsetBitsDefault
) (
  input  logic        clk,
  input  logic        rst,
  // source byte channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  ch,
  // token channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  kind,
  output logic [15:0] symbol_code,
  output logic [15:0] start_res,
  output logic [15:0] length,
  output logic        last
);

  blx_pkg::token_pair_t toks;
  blx_pkg::token_t      head;
  logic                 room;
  logic                 take;

  // a request is taken whenever the queue can absorb the worst case of two tokens
  assign in_stall = !room;
  assign take     = in_valid && room;

  // decode and state: the byte is consumed in the cycle it is taken
  blx_scan #(
    .OFFSET_BITS(OFFSET_BITS)
  ) u_scan (
    .clk  (clk),
    .rst  (rst),
    .take (take),
    .ch   (ch),
    .toks (toks)
  );

  // result queue parts the input side from the output side
  blx_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (take),
    .toks       (toks),
    .room       (room),
    .head_valid (out_valid),
    .pop        (!out_stall),
    .head       (head)
  );

  // token fields straight from the queue head
  assign kind        = head.kind;
  assign symbol_code = head.symbol_code;
  assign start_res   = head.start_res;
  assign length      = head.length;
  assign last        = head.last;

endmodule
